@@ rtl/rnr_pkg.sv @@
// Shared types and constants of the Newton-Raphson reciprocal unit.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package rnr_pkg;

  localparam int unsigned ITERATIONS = 8;

  localparam int unsigned X_W     = 16;
  localparam int unsigned Z_W     = 32;
  localparam int unsigned M_W     = 31;
  localparam int unsigned RECIP_W = 18;

  // Q2.30 constants: 48/17 and 32/17, rounded to nearest.
  localparam logic [Z_W-1:0] SEED_BIAS  = 32'd3031741621;
  localparam logic [M_W-1:0] SEED_SLOPE = 31'd2021161080;
  localparam logic [Z_W-1:0] ONE_Q30    = 32'd1073741824;
  localparam logic [Z_W-1:0] Z_MAX      = 32'hFFFF_FFFF;

  localparam logic [X_W-1:0]     X_MIN     = 16'd32768;
  localparam logic [RECIP_W-1:0] RECIP_MAX = 18'd131072;

  // Stages: two for the seed, three per cell, one output register.
  localparam int unsigned CELL_STAGES = 3;
  localparam int unsigned LATENCY     = 2 + CELL_STAGES * ITERATIONS + 1;

  // One operand in flight between two cells.
  typedef struct packed {
    logic           vld;
    logic [X_W-1:0] x;
    logic [Z_W-1:0] z;
  } rnr_word_t;

endpackage

@@ rtl/rnr_seed.sv @@
// Seed stage: clamp the operand and form z0 = 48/17 - 32/17*x in Q2.30.
// Depends on rnr_pkg.
`timescale 1ns / 1ps

module rnr_seed (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic [rnr_pkg::X_W-1:0] x_frac,
  output rnr_pkg::rnr_word_t     word_o
);
  import rnr_pkg::*;

  logic           vld1_r;
  logic [X_W-1:0] x1_r;
  logic [M_W-1:0] sx_r;
  logic [X_W-1:0] x_c;
  logic [M_W+X_W-1:0] sx_prod;
  rnr_word_t      word_r, word_nxt;

  // Clamp operands below one half to x = 0.5.
  assign x_c     = (x_frac < X_MIN) ? X_MIN : x_frac;
  assign sx_prod = SEED_SLOPE * {{M_W{1'b0}}, x_c};

  always_comb begin
    word_nxt.vld = vld1_r;
    word_nxt.x   = x1_r;
    word_nxt.z   = ({1'b0, sx_r} <= SEED_BIAS) ? (SEED_BIAS - {1'b0, sx_r}) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r     <= 1'b0;
      word_r.vld <= 1'b0;
    end else begin
      vld1_r     <= acc;
      word_r.vld <= word_nxt.vld;
    end
    x1_r     <= x_c;
    sx_r     <= sx_prod[M_W+X_W-1:X_W];
    word_r.x <= word_nxt.x;
    word_r.z <= word_nxt.z;
  end

  assign word_o = word_r;

endmodule

@@ rtl/rnr_cell.sv @@
// One Newton-Raphson step z = z + z*(1 - x*z) over three register stages.
// Depends on rnr_pkg.
`timescale 1ns / 1ps

module rnr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rnr_pkg::rnr_word_t word_i,
  output rnr_pkg::rnr_word_t word_o
);
  import rnr_pkg::*;

  // stage 1: x*z
  logic           vld1_r;
  logic [X_W-1:0] x1_r;
  logic [Z_W-1:0] z1_r, xz1_r;
  logic [X_W+Z_W-1:0] xz_prod;

  // stage 2: error term and direction
  logic           vld2_r, le2_r;
  logic [X_W-1:0] x2_r;
  logic [Z_W-1:0] z2_r;
  logic [M_W-1:0] m2_r, m_nxt;
  logic           le_nxt;
  logic [Z_W-1:0] e_full;

  // stage 3: correction and update
  logic [Z_W+M_W-1:0] dz_prod;
  logic [Z_W-1:0]     d;
  logic [Z_W:0]       sum;
  rnr_word_t          word_r, word_nxt;

  assign xz_prod = {{Z_W{1'b0}}, word_i.x} * {{X_W{1'b0}}, word_i.z};

  always_comb begin
    le_nxt = (xz1_r <= ONE_Q30);
    e_full = le_nxt ? (ONE_Q30 - xz1_r) : (xz1_r - ONE_Q30);
    // Clamp an over-unity error to one.
    if (!le_nxt && (e_full > ONE_Q30)) begin
      m_nxt = ONE_Q30[M_W-1:0];
    end else begin
      m_nxt = e_full[M_W-1:0];
    end
  end

  assign dz_prod = {{M_W{1'b0}}, z2_r} * {{Z_W{1'b0}}, m2_r};
  assign d       = dz_prod[Z_W+30-1:30];
  assign sum     = {1'b0, z2_r} + {1'b0, d};

  always_comb begin
    word_nxt.vld = vld2_r;
    word_nxt.x   = x2_r;
    if (le2_r) begin
      word_nxt.z = sum[Z_W] ? Z_MAX : sum[Z_W-1:0];
    end else begin
      word_nxt.z = (d > z2_r) ? '0 : (z2_r - d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      word_r.vld <= 1'b0;
    end else begin
      vld1_r     <= word_i.vld;
      vld2_r     <= vld1_r;
      word_r.vld <= word_nxt.vld;
    end
    x1_r     <= word_i.x;
    z1_r     <= word_i.z;
    xz1_r    <= xz_prod[X_W+Z_W-1:X_W];
    x2_r     <= x1_r;
    z2_r     <= z1_r;
    m2_r     <= m_nxt;
    le2_r    <= le_nxt;
    word_r.x <= word_nxt.x;
    word_r.z <= word_nxt.z;
  end

  assign word_o = word_r;

endmodule

@@ rtl/reciprocal_newton_raphson_top.sv @@
// Top level of the Newton-Raphson reciprocal unit: seed stage, a chain of
// iteration cells and the output register. Depends on rnr_pkg, rnr_seed, rnr_cell.
`timescale 1ns / 1ps

//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------------
//  input   | in_x_frac[15:0]            | word taken when start && !busy
//  result  | out_recip[17:0], out_valid | strobe for one cycle, no back-pressure
//
// Rate: one word per cycle sustained; each result passes through 2 seed stages,
// 3 stages per iteration cell and 1 output register after its start. Each cell
// holds one 16x32 and one 32x31 multiplier. busy is always low: the pipeline
// never stalls and the receiver cannot hold results off. Reset (rst_n,
// synchronous) drops every word in flight.

module reciprocal_newton_raphson_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rnr_pkg::X_W-1:0]     in_x_frac,
  output logic                        out_valid,
  output logic [rnr_pkg::RECIP_W-1:0] out_recip
);
  import rnr_pkg::*;

  rnr_word_t chain [0:ITERATIONS];
  logic                 acc;
  logic                 out_valid_r;
  logic [RECIP_W-1:0]   out_recip_r, recip_nxt;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  rnr_seed u_seed (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .x_frac (in_x_frac),
    .word_o (chain[0])
  );

  // Advance each word through one cell per iteration.
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    rnr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  // Drop the 14 extra fraction bits and saturate at 2.0.
  always_comb begin
    if (chain[ITERATIONS].z[Z_W-1:Z_W-RECIP_W] > RECIP_MAX) begin
      recip_nxt = RECIP_MAX;
    end else begin
      recip_nxt = chain[ITERATIONS].z[Z_W-1:Z_W-RECIP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[ITERATIONS].vld;
    end
    out_recip_r <= recip_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_recip = out_recip_r;

  // Every result traces back to a word taken at the input with start && !busy.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching start");

  // Saturation keeps the result at or below 2.0.
  a_sat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_recip <= RECIP_MAX))
    else $error("result above saturation limit");

  // A word leaving the last cell shows up as a strobe in the cycle after.
  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    chain[ITERATIONS].vld |=> out_valid)
    else $error("word lost at output register");

endmodule
